// File: rtl/core/tlptm_pkg.sv
// Shared types and constants of the two-level page table manager.
`default_nettype none

package tlptm_pkg;

  localparam int unsigned FRAME_W     = 20;
  localparam int unsigned FLAG_W      = 12;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned ACT_W       = 3;
  localparam int unsigned STAT_W      = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned DIR_ENTRIES = 1024;
  localparam int unsigned ENTRY_W     = 32;

  localparam int unsigned TABLE_SLOTS_DEF = 64;
  localparam int unsigned FREE_FRAMES_DEF = 4096;

  localparam logic [FRAME_W-1:0] LOW_FRAME_RST  = 20'd256;
  localparam logic [FRAME_W-1:0] HIGH_FRAME_RST = 20'd16384;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_FRAME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_FRAME = 2'd1;

  // actions
  localparam logic [ACT_W-1:0] ACT_FREE   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ALLOC  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MAP    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UNMAP  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_AMAP   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] STS_OK          = 3'd0;
  localparam logic [STAT_W-1:0] STS_NO_SLOT     = 3'd1;
  localparam logic [STAT_W-1:0] STS_REMAP       = 3'd2;
  localparam logic [STAT_W-1:0] STS_NO_TABLE    = 3'd3;
  localparam logic [STAT_W-1:0] STS_NOT_PRESENT = 3'd4;
  localparam logic [STAT_W-1:0] STS_NOT_USER    = 3'd5;
  localparam logic [STAT_W-1:0] STS_NO_FRAMES   = 3'd6;
  localparam logic [STAT_W-1:0] STS_RANGE       = 3'd7;

  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_USER    = 2;

  typedef struct packed {
    logic               rd;     // fetch the top of stack
    logic               push;
    logic               pop;
    logic [FRAME_W-1:0] frame;
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FRAME_W-1:0] frame;
    logic [FLAG_W-1:0]  flags;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/tlptm_frame_stack.sv
// LIFO of free page frames held in a synchronous memory.
`default_nettype none

module tlptm_frame_stack #(
  parameter int unsigned FREE_FRAMES = tlptm_pkg::FREE_FRAMES_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire tlptm_pkg::stk_cmd_t                   cmd_i,
  output logic [tlptm_pkg::FRAME_W-1:0]              top_o,
  output tlptm_pkg::stk_stat_t                       stat_o,
  output logic [$clog2(FREE_FRAMES+1)-1:0]           count_o
);
  import tlptm_pkg::*;

  localparam int unsigned SW = (FREE_FRAMES > 1) ? $clog2(FREE_FRAMES) : 1;
  localparam int unsigned CW = $clog2(FREE_FRAMES + 1);

  logic [FRAME_W-1:0] stk_mem [FREE_FRAMES];
  logic [CW-1:0]      count_q, count_d, count_m1;
  logic [FRAME_W-1:0] top_q;

  assign count_m1 = count_q - 1'b1;

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop) begin
      count_d = count_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stk_mem[count_q[SW-1:0]] <= cmd_i.frame;
    end
    if (cmd_i.rd) begin
      top_q <= stk_mem[count_m1[SW-1:0]];
    end
  end

  assign top_o        = top_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CW'(FREE_FRAMES));
  assign count_o      = count_q;

endmodule

`default_nettype wire

// File: rtl/core/two_level_page_table_manager_unit.sv
// Top level of the two-level page table manager with its free frame stack.
`default_nettype none

// One word in, one result word out. Directory and page tables share one
// synchronous memory (directory in the region above the table pool), the
// free frame stack has a memory of its own. Frame free/allocate words and
// ignored actions pass through accept and stack access; map, unmap,
// allocate-and-map and lookup pass through accept, directory read and table
// read-modify-write, set by the dependent reads through the table memory,
// or end after the directory read when the directory entry is missing and
// no table gets made. After reset the block clears the table memory, one
// entry a cycle, all (TABLE_SLOTS+1)*1024 entries, and takes no word
// meanwhile; configuration writes are taken always.
// A result waiting on a stalled output does not block the next input word;
// the one after it waits until the output register frees.
module two_level_page_table_manager_unit #(
  parameter int unsigned TABLE_SLOTS = tlptm_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned FREE_FRAMES = tlptm_pkg::FREE_FRAMES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // slave stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [55:0]                        s_axis_tdata,  // virt_page, phys_frame, perm
  input  wire logic [tlptm_pkg::ACT_W-1:0]        s_axis_tuser,  // action
  // master stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [31:0]                             m_axis_tdata,  // frame, flags
  output logic [tlptm_pkg::STAT_W-1:0]            m_axis_tuser,  // status
  // configuration writes
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [tlptm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [tlptm_pkg::FRAME_W-1:0]      cfg_data_i
);
  import tlptm_pkg::*;

  localparam int unsigned POOL_DEPTH = (TABLE_SLOTS + 1) * DIR_ENTRIES;
  localparam int unsigned ADDR_W     = $clog2(POOL_DEPTH);
  localparam int unsigned SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned NS_W       = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned CW         = $clog2(FREE_FRAMES + 1);
  localparam logic [ADDR_W-1:0] DIR_BASE = ADDR_W'(TABLE_SLOTS * DIR_ENTRIES);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(POOL_DEPTH - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIR   = 3'd2;
  localparam logic [2:0] S_TBL   = 3'd3;
  localparam logic [2:0] S_HOLD  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic [NS_W-1:0]    next_slot_q, next_slot_d;
  logic [FRAME_W-1:0] low_q, high_q;

  logic [ACT_W-1:0]   act_q;
  logic [FRAME_W-1:0] vpage_q, pframe_q;
  logic [FLAG_W-1:0]  perm_q;
  logic [ADDR_W-1:0]  tbl_addr_q;

  logic               out_valid_q, out_valid_d, out_load;
  res_t               out_q, out_d, hold_q, hold_d, res;
  logic               fin, out_free;

  logic [ENTRY_W-1:0] tbl_mem [POOL_DEPTH];
  logic [ENTRY_W-1:0] mem_rdata_q, mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr, mem_waddr;
  logic               mem_we;

  stk_cmd_t           stk_cmd;
  stk_stat_t          stk_stat;
  logic [FRAME_W-1:0] stk_top;
  logic [CW-1:0]      stk_count;

  logic               accept;
  logic               dir_present;
  logic [SLOT_W-1:0]  dir_slot, new_slot;
  logic [FRAME_W-1:0] ent_frame;
  logic [FLAG_W-1:0]  new_flags;
  logic [FRAME_W-1:0] map_frame;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign dir_present = mem_rdata_q[0];
  assign dir_slot    = mem_rdata_q[SLOT_W:1];
  assign new_slot    = next_slot_q[SLOT_W-1:0];
  assign ent_frame   = mem_rdata_q[ENTRY_W-1 -: FRAME_W];
  assign new_flags   = {perm_q[FLAG_W-1:1], 1'b1};
  assign map_frame   = (act_q == ACT_AMAP) ? stk_top : pframe_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    next_slot_d = next_slot_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = DIR_BASE + ADDR_W'(s_axis_tdata[FRAME_W-1 -: IDX_W]);
    stk_cmd     = '0;
    res         = '0;
    fin         = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          stk_cmd.rd = 1'b1;
          state_d    = S_DIR;
        end
      end
      S_DIR: begin
        unique case (act_q)
          ACT_FREE: begin
            fin = 1'b1;
            if (pframe_q < low_q || pframe_q > high_q) begin
              res.status = STS_RANGE;
            end else if (stk_stat.full) begin
              res.status = STS_NO_FRAMES;
            end else begin
              stk_cmd.push  = 1'b1;
              stk_cmd.frame = pframe_q;
            end
          end
          ACT_ALLOC: begin
            fin = 1'b1;
            if (stk_stat.empty) begin
              res.status = STS_NO_FRAMES;
            end else begin
              stk_cmd.pop = 1'b1;
              res.frame   = stk_top;
            end
          end
          ACT_MAP, ACT_AMAP: begin
            if (dir_present) begin
              mem_raddr = ADDR_W'({dir_slot, vpage_q[IDX_W-1:0]});
              state_d   = S_TBL;
            end else if (next_slot_q == NS_W'(TABLE_SLOTS)) begin
              fin        = 1'b1;
              res.status = STS_NO_SLOT;
            end else begin
              // new table; the pool region was cleared, so it reads empty
              mem_we                = 1'b1;
              mem_waddr             = DIR_BASE + ADDR_W'(vpage_q[FRAME_W-1 -: IDX_W]);
              mem_wdata[0]          = 1'b1;
              mem_wdata[SLOT_W:1]   = new_slot;
              next_slot_d           = next_slot_q + 1'b1;
              mem_raddr             = ADDR_W'({new_slot, vpage_q[IDX_W-1:0]});
              state_d               = S_TBL;
            end
          end
          ACT_UNMAP, ACT_LOOKUP: begin
            if (dir_present) begin
              mem_raddr = ADDR_W'({dir_slot, vpage_q[IDX_W-1:0]});
              state_d   = S_TBL;
            end else begin
              fin        = 1'b1;
              res.status = STS_NO_TABLE;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_TBL: begin
        fin = 1'b1;
        unique case (act_q)
          ACT_MAP, ACT_AMAP: begin
            if (mem_rdata_q[BIT_PRESENT]) begin
              res.status = STS_REMAP;
              res.flags  = mem_rdata_q[FLAG_W-1:0];
            end else if (act_q == ACT_AMAP && stk_stat.empty) begin
              res.status = STS_NO_FRAMES;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = tbl_addr_q;
              mem_wdata = {map_frame, new_flags};
              res.flags = new_flags;
              if (act_q == ACT_AMAP) begin
                stk_cmd.pop = 1'b1;
                res.frame   = map_frame;
              end
            end
          end
          ACT_UNMAP: begin
            res.flags = mem_rdata_q[FLAG_W-1:0];
            if (!mem_rdata_q[BIT_PRESENT]) begin
              res.status = STS_NOT_PRESENT;
            end else begin
              res.frame = ent_frame;
              mem_we    = 1'b1;
              mem_waddr = tbl_addr_q;
              if (ent_frame < low_q || ent_frame > high_q) begin
                res.status = STS_RANGE;
              end else if (stk_stat.full) begin
                res.status = STS_NO_FRAMES;
              end else begin
                stk_cmd.push  = 1'b1;
                stk_cmd.frame = ent_frame;
              end
            end
          end
          ACT_LOOKUP: begin
            res.flags = mem_rdata_q[FLAG_W-1:0];
            if (!mem_rdata_q[BIT_PRESENT]) begin
              res.status = STS_NOT_PRESENT;
            end else if (!mem_rdata_q[BIT_USER]) begin
              res.status = STS_NOT_USER;
            end else begin
              res.frame = ent_frame;
            end
          end
          default: begin
            res = '0;
          end
        endcase
      end
      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = out_free ? S_IDLE : S_HOLD;
    end
  end

  // output register and the slot that waits behind it
  always_comb begin
    out_load = 1'b0;
    out_d    = out_q;
    hold_d   = hold_q;
    if (fin) begin
      if (out_free) begin
        out_load = 1'b1;
        out_d    = res;
      end else begin
        hold_d   = res;
      end
    end else if (state_q == S_HOLD && out_free) begin
      out_load = 1'b1;
      out_d    = hold_q;
    end
    out_valid_d = out_load || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      next_slot_q <= '0;
      out_valid_q <= 1'b0;
      low_q       <= LOW_FRAME_RST;
      high_q      <= HIGH_FRAME_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      next_slot_q <= next_slot_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_LOW_FRAME: begin
            low_q <= cfg_data_i;
          end
          REG_HIGH_FRAME: begin
            high_q <= cfg_data_i;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= s_axis_tuser;
      vpage_q  <= s_axis_tdata[FRAME_W-1:0];
      pframe_q <= s_axis_tdata[2*FRAME_W-1 -: FRAME_W];
      perm_q   <= s_axis_tdata[2*FRAME_W+FLAG_W-1 -: FLAG_W];
    end
    if (state_q == S_DIR) begin
      tbl_addr_q <= mem_raddr;
    end
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  // directory and table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= tbl_mem[mem_raddr];
  end

  tlptm_frame_stack #(
    .FREE_FRAMES(FREE_FRAMES)
  ) u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (stk_cmd),
    .top_o  (stk_top),
    .stat_o (stk_stat),
    .count_o(stk_count)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.flags, out_q.frame};
  assign m_axis_tuser  = out_q.status;

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_slot_q <= NS_W'(TABLE_SLOTS))
    else $error("table slot counter beyond pool size");

  a_new_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIR && mem_we) |=> next_slot_q == $past(next_slot_q) + 1'b1)
    else $error("directory write without table allocation");

  a_stack_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_HOLD || state_q == S_CLEAR) |=>
      stk_count == $past(stk_count))
    else $error("stack count moved outside an action");

  a_hold_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HOLD |-> out_valid_q)
    else $error("result held while output register empty");

endmodule

`default_nettype wire

// File: tb/tlptm_checker.sv
// Checker for the page table manager: predicts each result word and compares it with the output.
module tlptm_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [55:0]                     s_axis_tdata,   // virt_page, phys_frame, perm
  input  logic [tlptm_pkg::ACT_W-1:0]     s_axis_tuser,   // action
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [31:0]                     m_axis_tdata,   // frame, flags
  input  logic [tlptm_pkg::STAT_W-1:0]    m_axis_tuser,   // status
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [tlptm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tlptm_pkg::FRAME_W-1:0]   cfg_data_i,
  output int                              mismatches_o,
  output int                              results_due_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tlptm_pkg::*;

  localparam int unsigned POOL_DEPTH = TABLE_SLOTS_DEF * DIR_ENTRIES;
  localparam logic [FLAG_W-1:0] PRESENT_FLAG = FLAG_W'(1 << BIT_PRESENT);

  // page walk misses
  localparam int MISS_NO_TABLE = -1;
  localparam int MISS_NO_SLOT  = -2;

  logic [FRAME_W-1:0] low_frame;
  logic [FRAME_W-1:0] high_frame;
  logic               dir_valid [DIR_ENTRIES];
  int unsigned        dir_slot  [DIR_ENTRIES];
  logic [ENTRY_W-1:0] pte       [POOL_DEPTH];
  int unsigned        slots_used;
  logic [FRAME_W-1:0] free_stack [FREE_FRAMES_DEF];
  int unsigned        free_depth;
  res_t               due_results [$];
  int                 mismatches;

  // pool index of the page's entry; creates the table on demand when asked
  function automatic int entry_index(logic [FRAME_W-1:0] vp, bit create);
    logic [IDX_W-1:0] d;
    d = vp[FRAME_W-1:IDX_W];
    if (!dir_valid[d]) begin
      if (!create) return MISS_NO_TABLE;
      if (slots_used >= TABLE_SLOTS_DEF) return MISS_NO_SLOT;
      dir_valid[d] = 1'b1;
      dir_slot[d]  = slots_used;
      slots_used++;
    end
    return int'(dir_slot[d] * DIR_ENTRIES + vp[IDX_W-1:0]);
  endfunction

  function automatic logic [STAT_W-1:0] release_frame(logic [FRAME_W-1:0] f);
    if (f < low_frame || f > high_frame) return STS_RANGE;
    if (free_depth >= FREE_FRAMES_DEF) return STS_NO_FRAMES;
    free_stack[free_depth] = f;
    free_depth++;
    return STS_OK;
  endfunction

  function automatic res_t apply_action(logic [ACT_W-1:0] act, logic [FRAME_W-1:0] vp,
                                        logic [FRAME_W-1:0] pf, logic [FLAG_W-1:0] perm);
    res_t               r;
    int                 ix;
    logic [ENTRY_W-1:0] e;
    logic [FRAME_W-1:0] f;
    r = '0;
    case (act)
      ACT_FREE: r.status = release_frame(pf);
      ACT_ALLOC: begin
        if (free_depth == 0) begin
          r.status = STS_NO_FRAMES;
        end else begin
          free_depth--;
          r.frame = free_stack[free_depth];
        end
      end
      ACT_MAP, ACT_AMAP: begin
        ix = entry_index(vp, 1'b1);
        if (ix == MISS_NO_SLOT) begin
          r.status = STS_NO_SLOT;
        end else begin
          e = pte[ix];
          if (e[BIT_PRESENT]) begin
            r.status = STS_REMAP;
            r.flags  = e[FLAG_W-1:0];
          end else if (act == ACT_AMAP && free_depth == 0) begin
            r.status = STS_NO_FRAMES;  // a table made here stays
          end else begin
            if (act == ACT_MAP) begin
              f = pf;
            end else begin
              free_depth--;
              f = free_stack[free_depth];
              r.frame = f;
            end
            r.flags = perm | PRESENT_FLAG;
            pte[ix] = {f, r.flags};
          end
        end
      end
      ACT_UNMAP, ACT_LOOKUP: begin
        ix = entry_index(vp, 1'b0);
        if (ix == MISS_NO_TABLE) begin
          r.status = STS_NO_TABLE;
        end else begin
          e = pte[ix];
          r.flags = e[FLAG_W-1:0];
          if (!e[BIT_PRESENT]) begin
            r.status = STS_NOT_PRESENT;
          end else if (act == ACT_UNMAP) begin
            // entry goes away even when the frame is not taken back
            r.frame  = e[ENTRY_W-1:FLAG_W];
            pte[ix]  = '0;
            r.status = release_frame(r.frame);
          end else if (!e[BIT_USER]) begin
            r.status = STS_NOT_USER;
          end else begin
            r.frame = e[ENTRY_W-1:FLAG_W];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      low_frame  = LOW_FRAME_RST;
      high_frame = HIGH_FRAME_RST;
      slots_used = 0;
      free_depth = 0;
      for (int i = 0; i < DIR_ENTRIES; i++) begin
        dir_valid[i] = 1'b0;
        dir_slot[i]  = 0;
      end
      for (int i = 0; i < POOL_DEPTH; i++) pte[i] = '0;
      due_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_LOW_FRAME:  low_frame  = cfg_data_i;
          REG_HIGH_FRAME: high_frame = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        due_results.push_back(apply_action(s_axis_tuser, s_axis_tdata[19:0],
                                           s_axis_tdata[39:20], s_axis_tdata[51:40]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser;
        got.frame  = m_axis_tdata[19:0];
        got.flags  = m_axis_tdata[31:20];
        if (due_results.size() == 0) begin
          $error("result word with none outstanding: status %0d frame %h flags %h",
                 got.status, got.frame, got.flags);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
          end
          if (got.frame !== want.frame) begin
            $error("frame: expected %h, actual %h", want.frame, got.frame);
            mismatches++;
          end
          if (got.flags !== want.flags) begin
            $error("flags: expected %h, actual %h", want.flags, got.flags);
            mismatches++;
          end
        end
      end
    end
    mismatches_o  <= mismatches;
    results_due_o <= due_results.size();
  end

endmodule

// File: tb/tb.sv
// Testbench top: clock, reset, stimulus and verdict for the page table manager.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlptm_pkg::*;

  // action codes the block ignores
  localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;
  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  // receiver stall patterns
  localparam int RDY_ALWAYS = 0;
  localparam int RDY_COIN   = 1;
  localparam int RDY_SPARSE = 2;

  localparam int PHASE_WORDS = 353;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [55:0]          s_axis_tdata = '0;   // virt_page, phys_frame, perm
  logic [ACT_W-1:0]     s_axis_tuser = '0;   // action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;        // frame, flags
  logic [STAT_W-1:0]    m_axis_tuser;        // status
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FRAME_W-1:0]   cfg_data = '0;
  int                   mismatches;
  int                   results_due;

  logic [FRAME_W-1:0]   cur_low = LOW_FRAME_RST;
  logic [FRAME_W-1:0]   cur_high = HIGH_FRAME_RST;
  int unsigned          burst_left = 0;
  int unsigned          stall_left = 0;
  int                   stall_mode = RDY_ALWAYS;

  two_level_page_table_manager_unit u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  tlptm_checker u_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .results_due_o (results_due)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(RDY_SPARSE, RDY_ALWAYS);
      stall_left = $urandom_range(160, 16);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      RDY_ALWAYS: m_axis_tready <= 1'b1;
      RDY_COIN:   m_axis_tready <= 1'($urandom_range(1, 0));
      default:    m_axis_tready <= ($urandom_range(5, 0) == 0);
    endcase
  end

  // valid stays up within a burst; a gap follows each burst
  task automatic send_word(logic [ACT_W-1:0] act, logic [FRAME_W-1:0] vp,
                           logic [FRAME_W-1:0] pf, logic [FLAG_W-1:0] perm);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {4'b0, perm, pf, vp};
    do @(posedge clk); while (!s_axis_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 0);
    end
  endtask

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [FRAME_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // the write to a spare index must leave both registers alone
  task automatic program_range(logic [FRAME_W-1:0] lo, logic [FRAME_W-1:0] hi,
                               logic [CFG_IDX_W-1:0] spare);
    cfg_put(REG_LOW_FRAME, lo);
    cfg_put(REG_HIGH_FRAME, hi);
    cfg_put(spare, FRAME_W'($urandom));
    cfg_valid <= 1'b0;
    cur_low  = lo;
    cur_high = hi;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (8) @(posedge clk);
  endtask

  // mostly a handful of directory entries so that pages get hit again
  function automatic logic [FRAME_W-1:0] pick_page();
    logic [IDX_W-1:0] d;
    logic [IDX_W-1:0] t;
    if ($urandom_range(99, 0) < 15) return FRAME_W'($urandom);
    case ($urandom_range(5, 0))
      0:       d = 10'd0;
      1:       d = 10'd1;
      2:       d = 10'd2;
      3:       d = 10'd511;
      4:       d = 10'd512;
      default: d = 10'd1023;
    endcase
    t = $urandom_range(1, 0) ? IDX_W'($urandom_range(15, 0)) : IDX_W'($urandom_range(1023, 1008));
    return {d, t};
  endfunction

  function automatic logic [FRAME_W-1:0] pick_frame();
    int r;
    r = $urandom_range(99, 0);
    if (r < 10) return FRAME_W'($urandom);
    if (r < 30) begin
      case (r % 4)
        0:       return cur_low - 1'b1;
        1:       return cur_low;
        2:       return cur_high;
        default: return cur_high + 1'b1;
      endcase
    end
    if (cur_low <= cur_high) return FRAME_W'($urandom_range(cur_high, cur_low));
    return FRAME_W'($urandom);
  endfunction

  task automatic random_word();
    int                 r;
    logic [ACT_W-1:0]   act;
    logic [FRAME_W-1:0] pf;
    r = $urandom_range(99, 0);
    if (r < 20)      act = ACT_FREE;
    else if (r < 30) act = ACT_ALLOC;
    else if (r < 50) act = ACT_MAP;
    else if (r < 63) act = ACT_UNMAP;
    else if (r < 78) act = ACT_AMAP;
    else if (r < 95) act = ACT_LOOKUP;
    else             act = r[0] ? ACT_SPARE_A : ACT_SPARE_B;
    pf = (act == ACT_FREE || $urandom_range(1, 0)) ? pick_frame() : FRAME_W'($urandom);
    send_word(act, pick_page(), pf, FLAG_W'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    program_range(LOW_FRAME_RST, HIGH_FRAME_RST, REG_SPARE_A);

    // empty stack, missing tables, range edges, remap, user bit
    send_word(ACT_LOOKUP, 20'h00000, 20'h0, 12'h0);
    send_word(ACT_UNMAP,  20'hFFFFF, 20'h0, 12'h0);
    send_word(ACT_ALLOC,  20'h00000, 20'h0, 12'h0);
    send_word(ACT_AMAP,   20'h00000, 20'h0, 12'hFFF);
    send_word(ACT_FREE,   20'hFFFFF, 20'd255, 12'hFFF);
    send_word(ACT_FREE,   20'hFFFFF, 20'd256, 12'hFFF);
    send_word(ACT_FREE,   20'h00000, 20'd16384, 12'h000);
    send_word(ACT_FREE,   20'h00000, 20'd16385, 12'h000);
    send_word(ACT_FREE,   20'h00000, 20'hFFFFF, 12'h000);
    send_word(ACT_FREE,   20'h00000, 20'h00000, 12'h000);
    send_word(ACT_ALLOC,  20'h00000, 20'h0, 12'h0);
    send_word(ACT_MAP,    20'h00001, 20'hFFFFF, 12'hFFF);
    send_word(ACT_MAP,    20'h00001, 20'd5, 12'h000);
    send_word(ACT_LOOKUP, 20'h00001, 20'h0, 12'h0);
    send_word(ACT_MAP,    20'h00002, 20'd300, 12'h000);
    send_word(ACT_LOOKUP, 20'h00002, 20'h0, 12'h0);
    send_word(ACT_LOOKUP, 20'h00003, 20'h0, 12'h0);
    send_word(ACT_UNMAP,  20'h00003, 20'h0, 12'h0);
    send_word(ACT_UNMAP,  20'h00001, 20'h0, 12'h0);
    send_word(ACT_LOOKUP, 20'h00001, 20'h0, 12'h0);
    send_word(ACT_UNMAP,  20'h00002, 20'h0, 12'h0);
    send_word(ACT_AMAP,   20'hFFC05, 20'h0, 12'h004);
    send_word(ACT_AMAP,   20'hFFC05, 20'h0, 12'h000);
    send_word(ACT_SPARE_A, 20'hFFFFF, 20'hFFFFF, 12'hFFF);
    send_word(ACT_SPARE_B, 20'hFFFFF, 20'hFFFFF, 12'hFFF);
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: ;
        1: program_range(20'h00000, 20'hFFFFF, REG_SPARE_B);
        2: program_range(20'h00400, 20'h00400, REG_SPARE_A);
        3: program_range(20'hFFFFF, 20'h00000, REG_SPARE_B);
        default: program_range(20'd4096, 20'd8191, REG_SPARE_A);
      endcase
      repeat (PHASE_WORDS) random_word();
      drain();
    end

    // closing mixed run on the last range
    repeat (60) random_word();
    drain();

    if (mismatches == 0) begin
      $display("two_level_page_table_manager_unit verification clean");
    end else begin
      $display("two_level_page_table_manager_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("two_level_page_table_manager_unit verification failed");
    $finish;
  end

endmodule

// File: files.f
rtl/core/tlptm_pkg.sv
rtl/core/tlptm_frame_stack.sv
rtl/core/two_level_page_table_manager_unit.sv
tb/tlptm_checker.sv
tb/tb.sv
